// File: rtl/core/bnsg_pkg.sv
`default_nettype none

package bnsg_pkg;

  localparam int ANCHOR_W = 20;
  localparam int SEG_W    = 22;
  localparam int CALC_W   = 23;
  localparam int LVL_W    = 6;
  localparam int PC_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int LEN_W      = 21;

  typedef logic signed [LVL_W-1:0] lvl_t;
  typedef logic [PC_W-1:0]         pc_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLANK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTRA   = 3'd4;

  localparam logic [1:0] SHAPE_SQUARE_BR = 2'd0;
  localparam logic [1:0] SHAPE_VLINE     = 2'd1;
  localparam logic [1:0] SHAPE_HLINE     = 2'd2;
  localparam logic [1:0] SHAPE_SURROUND  = 2'd3;

  localparam pc_t PC_SQ  = 3'd0;
  localparam pc_t PC_VL  = 3'd1;
  localparam pc_t PC_HL  = 3'd2;
  localparam pc_t PC_HR  = 3'd3;
  localparam pc_t PC_SF  = 3'd4;
  localparam pc_t PC_SL  = 3'd5;
  localparam pc_t PC_SR  = 3'd6;
  localparam pc_t PC_ERR = 3'd7;

  typedef enum logic [1:0] {
    LS_T   = 2'd0,
    LS_TX1 = 2'd1,
    LS_TMW = 2'd2,
    LS_SQL = 2'd3
  } left_sel_e;

  typedef enum logic [1:0] {
    RS_T1  = 2'd0,
    RS_TW1 = 2'd1,
    RS_TMX = 2'd2
  } right_sel_e;

  typedef enum logic [1:0] {
    LO_HOLD     = 2'd0,
    LO_INC      = 2'd1,
    LO_INC_SKIP = 2'd2
  } lvl_op_e;

  typedef enum logic [1:0] {
    EC_NEVER  = 2'd0,
    EC_ALWAYS = 2'd1,
    EC_GE0    = 2'd2,
    EC_GEW    = 2'd3
  } end_cond_e;

  typedef enum logic [1:0] {
    JC_NONE   = 2'd0,
    JC_EQ_NX1 = 2'd1,
    JC_EQ_X   = 2'd2
  } jump_cond_e;

  typedef struct packed {
    logic       row_lvl;
    logic       err;
    left_sel_e  left_sel;
    right_sel_e right_sel;
    lvl_op_e    lvl_op;
    end_cond_e  end_cond;
    jump_cond_e jump_cond;
    pc_t        next_pc;
    pc_t        jump_pc;
  } ucode_t;

  typedef struct packed {
    logic       valid;
    logic       row_lvl;
    logic       err;
    logic       last;
    left_sel_e  left_sel;
    right_sel_e right_sel;
    lvl_t       level;
  } step_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t u;
    u = '{row_lvl: 1'b0, err: 1'b1, left_sel: LS_T, right_sel: RS_T1, lvl_op: LO_HOLD,
          end_cond: EC_ALWAYS, jump_cond: JC_NONE, next_pc: PC_ERR, jump_pc: PC_ERR};
    case (pc)
      PC_SQ: begin
        u = '{row_lvl: 1'b1, err: 1'b0, left_sel: LS_SQL, right_sel: RS_TW1,
              lvl_op: LO_INC, end_cond: EC_GE0, jump_cond: JC_NONE,
              next_pc: PC_SQ, jump_pc: PC_SQ};
      end
      PC_VL: begin
        u = '{row_lvl: 1'b1, err: 1'b0, left_sel: LS_T, right_sel: RS_T1,
              lvl_op: LO_INC_SKIP, end_cond: EC_GEW, jump_cond: JC_NONE,
              next_pc: PC_VL, jump_pc: PC_VL};
      end
      PC_HL: begin
        u = '{row_lvl: 1'b0, err: 1'b0, left_sel: LS_TMW, right_sel: RS_TMX,
              lvl_op: LO_HOLD, end_cond: EC_NEVER, jump_cond: JC_NONE,
              next_pc: PC_HR, jump_pc: PC_HR};
      end
      PC_HR: begin
        u = '{row_lvl: 1'b0, err: 1'b0, left_sel: LS_TX1, right_sel: RS_TW1,
              lvl_op: LO_HOLD, end_cond: EC_ALWAYS, jump_cond: JC_NONE,
              next_pc: PC_HR, jump_pc: PC_HR};
      end
      PC_SF: begin
        u = '{row_lvl: 1'b1, err: 1'b0, left_sel: LS_TMW, right_sel: RS_TW1,
              lvl_op: LO_INC, end_cond: EC_GEW, jump_cond: JC_EQ_NX1,
              next_pc: PC_SF, jump_pc: PC_SL};
      end
      PC_SL: begin
        u = '{row_lvl: 1'b1, err: 1'b0, left_sel: LS_TMW, right_sel: RS_TMX,
              lvl_op: LO_HOLD, end_cond: EC_NEVER, jump_cond: JC_NONE,
              next_pc: PC_SR, jump_pc: PC_SR};
      end
      PC_SR: begin
        u = '{row_lvl: 1'b1, err: 1'b0, left_sel: LS_TX1, right_sel: RS_TW1,
              lvl_op: LO_INC, end_cond: EC_NEVER, jump_cond: JC_EQ_X,
              next_pc: PC_SL, jump_pc: PC_SF};
      end
      default: begin
        u = '{row_lvl: 1'b0, err: 1'b1, left_sel: LS_T, right_sel: RS_T1,
              lvl_op: LO_HOLD, end_cond: EC_ALWAYS, jump_cond: JC_NONE,
              next_pc: PC_ERR, jump_pc: PC_ERR};
      end
    endcase
    return u;
  endfunction

  function automatic pc_t entry_pc(input logic [1:0] shape);
    pc_t pc;
    case (shape)
      SHAPE_SQUARE_BR: pc = PC_SQ;
      SHAPE_VLINE:     pc = PC_VL;
      SHAPE_HLINE:     pc = PC_HL;
      SHAPE_SURROUND:  pc = PC_SF;
      default:         pc = PC_SQ;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bin_neighbourhood_segment_generator_unit.sv
// Intake loads the sequencer pc and level registers, then the first segment is registered.
// Each anchor yields N segments (1 to 60, one on a bad exclusion), one per
// cycle from the microcode sequencer while the output side does not stall.
// The next anchor is taken the cycle after the last segment enters the output register.
// Reset: asynchronous, active low; clears control state and loads the register defaults.
`default_nettype none

module bin_neighbourhood_segment_generator_unit #(
  parameter int MAX_FLANK = 15,
  parameter int BIN_BITS  = 20
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [bnsg_pkg::ANCHOR_W-1:0]          anchor_row_i,
  input  wire logic [bnsg_pkg::ANCHOR_W-1:0]          anchor_col_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [bnsg_pkg::SEG_W-1:0]           seg_row_o,
  output logic signed [bnsg_pkg::SEG_W-1:0]           seg_left_o,
  output logic signed [bnsg_pkg::SEG_W-1:0]           seg_right_o,
  output logic                                        last_segment_o,
  output logic                                        config_error_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [bnsg_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [bnsg_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int AW = bnsg_pkg::ANCHOR_W;
  localparam int CW = bnsg_pkg::CALC_W;
  localparam int KeepBits = (BIN_BITS < AW) ? BIN_BITS : AW;
  localparam logic [AW-1:0] BinMask = {AW{1'b1}} >> (AW - KeepBits);
  localparam logic [3:0] FlankCap = 4'(MAX_FLANK);
  localparam logic signed [CW-1:0] OneStep = CW'(1);

  logic [1:0]                  shape_q;
  logic [3:0]                  flank_q, exclude_q;
  logic [bnsg_pkg::LEN_W-1:0]  length_q;
  logic                        intra_q;
  logic [AW-1:0]               row_q, col_q;
  logic [3:0]                  w_sat;
  logic                        bad_cfg, in_accept, adv, busy;
  bnsg_pkg::step_t             step;

  logic                        ov_q, ov_d;
  logic signed [bnsg_pkg::SEG_W-1:0] orow_q, oleft_q, oright_q;
  logic                        olast_q, oerr_q;

  logic signed [CW-1:0] a, t, l, w, x, row_v, left_v, right_v, left_c, right_c, len;

  assign cfg_ready_o = 1'b1;
  assign w_sat       = (flank_q > FlankCap) ? FlankCap : flank_q;
  assign bad_cfg     = (exclude_q >= w_sat);
  assign in_stall_o  = busy;
  assign in_accept   = in_valid_i & ~busy;
  assign adv         = ~ov_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q   <= bnsg_pkg::SHAPE_SQUARE_BR;
      flank_q   <= 4'd1;
      exclude_q <= 4'd0;
      length_q  <= 21'h100000;
      intra_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bnsg_pkg::CFG_SHAPE:   shape_q   <= cfg_data_i[1:0];
        bnsg_pkg::CFG_FLANK:   flank_q   <= cfg_data_i[3:0];
        bnsg_pkg::CFG_EXCLUDE: exclude_q <= cfg_data_i[3:0];
        bnsg_pkg::CFG_LENGTH:  length_q  <= cfg_data_i[bnsg_pkg::LEN_W-1:0];
        bnsg_pkg::CFG_INTRA:   intra_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      row_q <= anchor_row_i & BinMask;
      col_q <= anchor_col_i & BinMask;
    end
  end

  bnsg_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .bad_cfg_i (bad_cfg),
    .shape_i   (shape_q),
    .flank_i   (w_sat),
    .exclude_i (exclude_q),
    .adv_i     (adv),
    .busy_o    (busy),
    .step_o    (step)
  );

  always_comb begin
    a   = $signed({{(CW-AW){1'b0}}, row_q});
    t   = $signed({{(CW-AW){1'b0}}, col_q});
    l   = $signed({{(CW-bnsg_pkg::LVL_W){step.level[bnsg_pkg::LVL_W-1]}}, step.level});
    w   = $signed({{(CW-4){1'b0}}, w_sat});
    x   = $signed({{(CW-4){1'b0}}, exclude_q});
    len = $signed({{(CW-bnsg_pkg::LEN_W){1'b0}}, length_q});

    row_v = step.row_lvl ? (a + l) : a;

    case (step.left_sel)
      bnsg_pkg::LS_TX1: left_v = t + x + OneStep;
      bnsg_pkg::LS_TMW: left_v = t - w;
      default:          left_v = t;
    endcase

    case (step.right_sel)
      bnsg_pkg::RS_TW1: right_v = t + w + OneStep;
      bnsg_pkg::RS_TMX: right_v = t - x;
      default:          right_v = t + OneStep;
    endcase

    left_c = left_v[CW-1] ? '0 : left_v;
    if (intra_q) begin
      right_c = (right_v > row_v) ? (row_v + OneStep) : right_v;
    end else begin
      right_c = (right_v > len) ? len : right_v;
    end
    if (left_c > right_c) begin
      left_c = right_c;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (step.valid && adv) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.valid && adv) begin
      orow_q   <= step.err ? '0 : row_v[bnsg_pkg::SEG_W-1:0];
      oleft_q  <= step.err ? '0 : left_c[bnsg_pkg::SEG_W-1:0];
      oright_q <= step.err ? '0 : right_c[bnsg_pkg::SEG_W-1:0];
      olast_q  <= step.last;
      oerr_q   <= step.err;
    end
  end

  assign out_valid_o    = ov_q;
  assign seg_row_o      = orow_q;
  assign seg_left_o     = oleft_q;
  assign seg_right_o    = oright_q;
  assign last_segment_o = olast_q;
  assign config_error_o = oerr_q;

endmodule

`default_nettype wire

// File: rtl/core/bnsg_sequencer.sv
`default_nettype none

module bnsg_sequencer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            bad_cfg_i,
  input  wire logic [1:0]      shape_i,
  input  wire logic [3:0]      flank_i,
  input  wire logic [3:0]      exclude_i,
  input  wire logic            adv_i,
  output logic                 busy_o,
  output bnsg_pkg::step_t      step_o
);

  bnsg_pkg::pc_t    pc_q, pc_d;
  bnsg_pkg::lvl_t   lvl_q, lvl_d;
  logic             busy_q, busy_d;
  bnsg_pkg::ucode_t uw;
  bnsg_pkg::lvl_t   w_s, x_s, nx1, xp1, lvl_inc;
  logic             done, taken;

  assign uw      = bnsg_pkg::ucode_rom(pc_q);
  assign w_s     = bnsg_pkg::lvl_t'({2'b00, flank_i});
  assign x_s     = bnsg_pkg::lvl_t'({2'b00, exclude_i});
  assign nx1     = bnsg_pkg::lvl_t'(6'd0 - {2'b00, exclude_i} - 6'd1);
  assign xp1     = bnsg_pkg::lvl_t'({2'b00, exclude_i} + 6'd1);
  assign lvl_inc = bnsg_pkg::lvl_t'(lvl_q + 6'sd1);

  always_comb begin
    case (uw.end_cond)
      bnsg_pkg::EC_ALWAYS: done = 1'b1;
      bnsg_pkg::EC_GE0:    done = ~lvl_q[bnsg_pkg::LVL_W-1];
      bnsg_pkg::EC_GEW:    done = (lvl_q >= w_s);
      default:             done = 1'b0;
    endcase
    case (uw.jump_cond)
      bnsg_pkg::JC_EQ_NX1: taken = (lvl_q == nx1);
      bnsg_pkg::JC_EQ_X:   taken = (lvl_q == x_s);
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    lvl_d  = lvl_q;
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = bad_cfg_i ? bnsg_pkg::PC_ERR : bnsg_pkg::entry_pc(shape_i);
      lvl_d  = bnsg_pkg::lvl_t'(6'd0 - {2'b00, flank_i});
    end else if (busy_q && adv_i) begin
      if (done) begin
        busy_d = 1'b0;
        lvl_d  = '0;
      end else begin
        pc_d = taken ? uw.jump_pc : uw.next_pc;
        case (uw.lvl_op)
          bnsg_pkg::LO_INC:      lvl_d = lvl_inc;
          bnsg_pkg::LO_INC_SKIP: lvl_d = (lvl_q == nx1) ? xp1 : lvl_inc;
          default:               lvl_d = lvl_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= bnsg_pkg::PC_SQ;
      lvl_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      lvl_q  <= lvl_d;
      busy_q <= busy_d;
    end
  end

  always_comb begin
    step_o.valid     = busy_q;
    step_o.row_lvl   = uw.row_lvl;
    step_o.err       = uw.err;
    step_o.last      = done;
    step_o.right_sel = uw.right_sel;
    step_o.level     = lvl_q;
    if (uw.left_sel == bnsg_pkg::LS_SQL) begin
      step_o.left_sel = (lvl_q < -x_s) ? bnsg_pkg::LS_T : bnsg_pkg::LS_TX1;
    end else begin
      step_o.left_sel = uw.left_sel;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// File: tb/bin_neighbourhood_segment_checker.sv
`timescale 1ns / 1ps

module bin_neighbourhood_segment_checker
  import bnsg_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_i,
  input  wire logic [ANCHOR_W-1:0]         anchor_row_i,
  input  wire logic [ANCHOR_W-1:0]         anchor_col_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_stall_i,
  input  wire logic signed [SEG_W-1:0]     seg_row_i,
  input  wire logic signed [SEG_W-1:0]     seg_left_i,
  input  wire logic signed [SEG_W-1:0]     seg_right_i,
  input  wire logic                        last_segment_i,
  input  wire logic                        config_error_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int MAX_FLANK = 15;
  localparam int MAX_SEGS  = 4 * MAX_FLANK;

  typedef enum logic [1:0] {
    SWEEP_FULL,
    SWEEP_LEFT,
    SWEEP_RIGHT
  } sweep_phase_e;

  typedef struct packed {
    logic signed [SEG_W-1:0] row;
    logic signed [SEG_W-1:0] left;
    logic signed [SEG_W-1:0] right;
    logic                    last;
    logic                    err;
  } segment_t;

  logic [1:0]        cfg_shape   = SHAPE_SQUARE_BR;
  logic [3:0]        cfg_flank   = 4'd1;
  logic [3:0]        cfg_exclude = 4'd0;
  logic [LEN_W-1:0]  cfg_length  = 21'd1048576;
  logic              cfg_intra   = 1'b1;

  segment_t expected_segs[$];

  function automatic segment_t clip_segment(input longint row, input longint left,
                                            input longint right);
    segment_t s;
    longint   lo;
    longint   hi;
    lo = left;
    hi = right;
    if (lo < 0) lo = 0;
    if (cfg_intra) begin
      if (hi > row) hi = row + 1;
    end else if (hi > longint'(cfg_length)) begin
      hi = longint'(cfg_length);
    end
    if (lo > hi) lo = hi;
    s.row   = row[SEG_W-1:0];
    s.left  = lo[SEG_W-1:0];
    s.right = hi[SEG_W-1:0];
    s.last  = 1'b0;
    s.err   = 1'b0;
    return s;
  endfunction

  function automatic void predict_anchor(input logic [ANCHOR_W-1:0] row,
                                         input logic [ANCHOR_W-1:0] col);
    longint       w;
    longint       x;
    longint       a;
    longint       t;
    longint       lvl;
    sweep_phase_e ph;
    logic         left_first;
    logic         more;
    int           n;
    segment_t     s;
    w = (cfg_flank > MAX_FLANK) ? MAX_FLANK : cfg_flank;
    x = cfg_exclude;
    if (x >= w) begin
      s      = '0;
      s.last = 1'b1;
      s.err  = 1'b1;
      expected_segs.push_back(s);
      return;
    end
    a          = row;
    t          = col;
    lvl        = (cfg_shape == SHAPE_HLINE) ? 0 : -w;
    ph         = SWEEP_FULL;
    left_first = 1'b1;
    n          = 0;
    more       = 1'b1;
    while (more) begin
      case (cfg_shape)
        SHAPE_SQUARE_BR: s = clip_segment(a + lvl, (lvl < -x) ? t : t + x + 1, t + w + 1);
        SHAPE_VLINE:     s = clip_segment(a + lvl, t, t + 1);
        SHAPE_HLINE: begin
          if (left_first) s = clip_segment(a, t - w, t - x);
          else s = clip_segment(a, t + x + 1, t + w + 1);
        end
        default: begin
          case (ph)
            SWEEP_FULL: s = clip_segment(a + lvl, t - w, t + w + 1);
            SWEEP_LEFT: s = clip_segment(a + lvl, t - w, t - x);
            default:    s = clip_segment(a + lvl, t + x + 1, t + w + 1);
          endcase
        end
      endcase
      n++;
      more = (n < MAX_SEGS);
      if (more) begin
        case (cfg_shape)
          SHAPE_SQUARE_BR: begin
            if (lvl >= 0) more = 1'b0;
            else lvl++;
          end
          SHAPE_VLINE: begin
            if (lvl >= w) begin
              more = 1'b0;
            end else begin
              lvl++;
              if (lvl == -x) lvl = x + 1;
            end
          end
          SHAPE_HLINE: begin
            if (left_first) left_first = 1'b0;
            else more = 1'b0;
          end
          default: begin
            if (ph == SWEEP_FULL) begin
              if (lvl == -x - 1) ph = SWEEP_LEFT;
              else if (lvl >= w) more = 1'b0;
              if (more) lvl++;
            end else if (ph == SWEEP_LEFT) begin
              ph = SWEEP_RIGHT;
            end else begin
              ph = (lvl == x) ? SWEEP_FULL : SWEEP_LEFT;
              lvl++;
            end
          end
        endcase
      end
      if (!more) s.last = 1'b1;
      expected_segs.push_back(s);
    end
  endfunction

  function automatic bit field_differs(input string name, input logic signed [SEG_W-1:0] exp_v,
                                       input logic signed [SEG_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin
    segment_t exp_seg;
    bit       bad;
    if (!rst_ni) begin
      cfg_shape   = SHAPE_SQUARE_BR;
      cfg_flank   = 4'd1;
      cfg_exclude = 4'd0;
      cfg_length  = 21'd1048576;
      cfg_intra   = 1'b1;
      expected_segs.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SHAPE:   cfg_shape   = cfg_data_i[1:0];
          CFG_FLANK:   cfg_flank   = cfg_data_i[3:0];
          CFG_EXCLUDE: cfg_exclude = cfg_data_i[3:0];
          CFG_LENGTH:  cfg_length  = cfg_data_i[LEN_W-1:0];
          CFG_INTRA:   cfg_intra   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_anchor(anchor_row_i, anchor_col_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_segs.size() == 0) begin
          $display("%0t: unexpected word, row %0d left %0d right %0d last %0d err %0d",
                   $time, seg_row_i, seg_left_i, seg_right_i, last_segment_i,
                   config_error_i);
          fail_count_o++;
        end else begin
          exp_seg = expected_segs.pop_front();
          bad = 1'b0;
          bad |= field_differs("seg_row", exp_seg.row, seg_row_i);
          bad |= field_differs("seg_left", exp_seg.left, seg_left_i);
          bad |= field_differs("seg_right", exp_seg.right, seg_right_i);
          bad |= field_differs("last_segment", exp_seg.last, last_segment_i);
          bad |= field_differs("config_error", exp_seg.err, config_error_i);
          if (bad) fail_count_o++;
        end
      end
    end
    pending_o = expected_segs.size();
  end

endmodule

// File: tb/bin_neighbourhood_segment_generator_unit_tb.sv
`timescale 1ns / 1ps

module bin_neighbourhood_segment_generator_unit_tb;
  import bnsg_pkg::*;

  localparam int                   CYCLE_LIMIT      = 500000;
  localparam int                   LONG_HOLD_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO    = 3'd5;
  localparam logic [ANCHOR_W-1:0]  BIN_MAX          = 20'hFFFFF;
  localparam logic [LEN_W-1:0]     LEN_DEFAULT      = 21'd1048576;
  localparam logic [LEN_W-1:0]     LEN_MAX          = 21'h1FFFFF;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ANCHOR_W-1:0]     anchor_row_i;
  logic [ANCHOR_W-1:0]     anchor_col_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [SEG_W-1:0] seg_row_o;
  logic signed [SEG_W-1:0] seg_left_o;
  logic signed [SEG_W-1:0] seg_right_o;
  logic                    last_segment_o;
  logic                    config_error_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  int               fail_count;
  int               pending_segs;
  int               cycle_count = 0;
  int               burst_left  = 0;
  int               long_hold_reqs = 0;
  logic [LEN_W-1:0] cur_length  = LEN_DEFAULT;

  bin_neighbourhood_segment_generator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .anchor_row_i   (anchor_row_i),
    .anchor_col_i   (anchor_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .seg_row_o      (seg_row_o),
    .seg_left_o     (seg_left_o),
    .seg_right_o    (seg_right_o),
    .last_segment_o (last_segment_o),
    .config_error_o (config_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  bin_neighbourhood_segment_checker i_segment_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .anchor_row_i   (anchor_row_i),
    .anchor_col_i   (anchor_col_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .seg_row_i      (seg_row_o),
    .seg_left_i     (seg_left_o),
    .seg_right_i    (seg_right_o),
    .last_segment_i (last_segment_o),
    .config_error_i (config_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending_segs)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int mode;
    int stretch;
    int hold_left;
    int holds_served;
    out_stall_i  = 1'b0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 80);
      repeat (stretch) begin
        @(negedge clk_i);
        if (long_hold_reqs != holds_served) begin
          holds_served = long_hold_reqs;
          hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall_i <= 1'b1;
        end else begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= 1'($urandom_range(0, 1));
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] shape, input logic [3:0] flank,
                            input logic [3:0] excl, input logic [LEN_W-1:0] len,
                            input logic intra, input bit junk_en);
    logic [CFG_DATA_W-1:0] junk;
    junk = junk_en ? CFG_DATA_W'($urandom) : '0;
    write_reg(CFG_SHAPE, {junk[CFG_DATA_W-1:2], shape});
    junk = junk_en ? CFG_DATA_W'($urandom) : '0;
    write_reg(CFG_FLANK, {junk[CFG_DATA_W-1:4], flank});
    junk = junk_en ? CFG_DATA_W'($urandom) : '0;
    write_reg(CFG_EXCLUDE, {junk[CFG_DATA_W-1:4], excl});
    write_reg(CFG_LENGTH, len);
    junk = junk_en ? CFG_DATA_W'($urandom) : '0;
    write_reg(CFG_INTRA, {junk[CFG_DATA_W-1:1], intra});
    cur_length = len;
  endtask

  task automatic send_anchor(input logic [ANCHOR_W-1:0] row, input logic [ANCHOR_W-1:0] col);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    anchor_row_i <= row;
    anchor_col_i <= col;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and hold until every segment has drained
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_segs != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [ANCHOR_W-1:0] pick_bin();
    case ($urandom_range(0, 3))
      0:       return ANCHOR_W'($urandom_range(0, 20));
      1:       return BIN_MAX - ANCHOR_W'($urandom_range(0, 20));
      default: return ANCHOR_W'($urandom);
    endcase
  endfunction

  task automatic send_random_anchor;
    logic [ANCHOR_W-1:0] row;
    logic [ANCHOR_W-1:0] col;
    row = pick_bin();
    case ($urandom_range(0, 3))
      0:       col = row + ANCHOR_W'($urandom_range(0, 40)) - ANCHOR_W'(20);
      1:       col = pick_bin();
      2:       col = ANCHOR_W'(cur_length) - ANCHOR_W'($urandom_range(0, 20));
      default: col = ANCHOR_W'($urandom);
    endcase
    send_anchor(row, col);
  endtask

  task automatic random_config;
    logic [1:0]       shape;
    logic [3:0]       flank;
    logic [3:0]       excl;
    logic [LEN_W-1:0] len;
    shape = 2'($urandom_range(0, 3));
    flank = ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0 || flank == 0) excl = 4'($urandom_range(0, 15));
    else excl = 4'($urandom_range(0, flank - 1));
    case ($urandom_range(0, 4))
      0:       len = LEN_DEFAULT;
      1:       len = LEN_MAX;
      2:       len = LEN_W'($urandom_range(0, 64));
      default: len = LEN_W'($urandom);
    endcase
    set_config(shape, flank, excl, len, 1'($urandom_range(0, 1)), 1'b1);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
  endtask

  initial begin
    int n_items;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    anchor_row_i = '0;
    anchor_col_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_SHAPE;
    cfg_data_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults
    send_anchor('0, '0);
    send_anchor(BIN_MAX, BIN_MAX);
    drain();

    set_config(SHAPE_SQUARE_BR, 4'd15, 4'd14, LEN_DEFAULT, 1'b1, 1'b0);
    send_anchor('0, '0);
    send_anchor(BIN_MAX, BIN_MAX);
    send_anchor(20'd5, BIN_MAX);
    drain();

    set_config(SHAPE_VLINE, 4'd15, 4'd0, '0, 1'b0, 1'b0);
    send_anchor('0, '0);
    send_anchor(BIN_MAX, '0);
    drain();

    set_config(SHAPE_HLINE, 4'd15, 4'd7, LEN_MAX, 1'b0, 1'b0);
    send_anchor(20'd10, 20'd3);
    send_anchor(BIN_MAX, BIN_MAX);
    drain();

    set_config(SHAPE_SURROUND, 4'd15, 4'd14, LEN_DEFAULT, 1'b1, 1'b0);
    send_anchor(20'd20, 20'd20);
    send_anchor(BIN_MAX, 20'd5);
    drain();

    // exclusion not below the flank
    set_config(SHAPE_SURROUND, 4'd0, 4'd0, LEN_DEFAULT, 1'b1, 1'b0);
    send_anchor(20'd7, 20'd7);
    drain();
    set_config(SHAPE_SQUARE_BR, 4'd5, 4'd9, LEN_DEFAULT, 1'b0, 1'b0);
    send_anchor(20'd100, 20'd90);
    drain();
    set_config(SHAPE_HLINE, 4'd15, 4'd15, LEN_MAX, 1'b1, 1'b0);
    send_anchor(BIN_MAX, '0);
    drain();

    set_config(SHAPE_SURROUND, 4'd1, 4'd0, 21'd100, 1'b0, 1'b0);
    send_anchor(20'd50, 20'd99);
    send_anchor('0, BIN_MAX);
    drain();

    set_config(SHAPE_SQUARE_BR, 4'd3, 4'd1, 21'd1048575, 1'b0, 1'b0);
    send_anchor(20'd2, '0);
    drain();

    for (int phase_idx = 0; phase_idx < 10; phase_idx++) begin
      random_config();
      if (phase_idx == 1 || phase_idx == 6) long_hold_reqs++;
      n_items = $urandom_range(10, 16);
      repeat (n_items) send_random_anchor();
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bnsg_pkg.sv
rtl/core/bnsg_sequencer.sv
rtl/core/bin_neighbourhood_segment_generator_unit.sv
tb/bin_neighbourhood_segment_checker.sv
tb/bin_neighbourhood_segment_generator_unit_tb.sv
